[src/edfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared constants, controller states and control/status words of the
// earliest-deadline-first scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

    localparam int EDFS_READY_SLOTS = 16;
    localparam int EDFS_TIME_BITS   = 16;
    localparam int ID_W             = 8;
    localparam int FIELD_W          = 16;

    localparam logic OP_ARRIVAL = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ARRIVE,
        S_PRE,
        S_RETIRE,
        S_RESCAN,
        S_START,
        S_FINAL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic scan_start;
        logic scan_free;
        logic do_arrive;
        logic do_swap;
        logic do_retire;
        logic do_start;
        logic do_final;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic scan_busy;
        logic found;
        logic preempt;
        logic retire;
        logic run_valid;
        logic swapped;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

[src/edf_preemptive_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_preemptive_scheduler
// Preemptive earliest-deadline-first scheduler with a ready table and one
// running task; arrival words store tasks, tick words schedule and advance.
// ----------------------------------------------------------------------------
// One word at a time. Every word starts with a scan of the ready table, one
// slot per cycle through the table memory read port, before an arrival or a
// tick goes on to its result. A tick whose preempting task retires at once
// needs a second scan. The result waits in an output register; the next word
// is taken while it waits.
// ----------------------------------------------------------------------------
module edf_preemptive_scheduler
    import edfs_pkg::*;
#(
    parameter int READY_SLOTS = EDFS_READY_SLOTS,
    parameter int TIME_BITS   = EDFS_TIME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [ID_W-1:0]    i_task_id,
    input  logic [FIELD_W-1:0] i_task_length,
    input  logic [FIELD_W-1:0] i_task_deadline,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_arrival_accepted,
    output logic               o_running_valid,
    output logic [ID_W-1:0]    o_running_task,
    output logic               o_task_started,
    output logic               o_retired_valid,
    output logic [ID_W-1:0]    o_retired_task,
    output logic               o_deadline_missed,
    output logic [FIELD_W-1:0] o_current_tick
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    edfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    edfs_dpath #(
        .READY_SLOTS (READY_SLOTS),
        .TIME_BITS   (TIME_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_op               (i_op),
        .i_task_id          (i_task_id),
        .i_task_length      (i_task_length),
        .i_task_deadline    (i_task_deadline),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_arrival_accepted (o_arrival_accepted),
        .o_running_valid    (o_running_valid),
        .o_running_task     (o_running_task),
        .o_task_started     (o_task_started),
        .o_retired_valid    (o_retired_valid),
        .o_retired_task     (o_retired_task),
        .o_deadline_missed  (o_deadline_missed),
        .o_current_tick     (o_current_tick)
    );

    a_missed_needs_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_deadline_missed) |-> o_retired_valid)
        else $error("deadline miss reported without a retired task");

    a_started_is_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_task_started) |-> o_running_valid)
        else $error("task started but nothing running");

    a_arrival_no_tick_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_arrival_accepted) |-> (!o_retired_valid && !o_task_started))
        else $error("arrival word carries tick results");

    a_one_word_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second word taken while one is in progress");

endmodule
`default_nettype wire

[src/edfs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_ctrl
// Sequencer of the scheduler: scan, arrive, preempt, retire, start, advance, output.
// ----------------------------------------------------------------------------
module edfs_ctrl
    import edfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_op,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.scan_busy) begin
                    n_state = (i_stat.op == OP_ARRIVAL) ? S_ARRIVE : S_PRE;
                end
            end
            S_ARRIVE: n_state = S_OUT;
            S_PRE:    n_state = S_RETIRE;
            S_RETIRE: begin
                if (i_stat.run_valid && !i_stat.retire) begin
                    n_state = S_FINAL;
                end else if (i_stat.swapped) begin
                    n_state = S_RESCAN;
                end else begin
                    n_state = S_START;
                end
            end
            S_RESCAN: begin
                if (!i_stat.scan_busy) begin
                    n_state = S_START;
                end
            end
            S_START: n_state = S_FINAL;
            S_FINAL: n_state = S_OUT;
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_free  = (i_op == OP_ARRIVAL);
                end
            end
            S_ARRIVE: o_cmd.do_arrive = i_stat.found;
            S_PRE:    o_cmd.do_swap   = i_stat.preempt;
            S_RETIRE: begin
                o_cmd.do_retire  = i_stat.retire;
                o_cmd.scan_start = (!i_stat.run_valid || i_stat.retire) && i_stat.swapped;
            end
            S_START:  o_cmd.do_start = i_stat.found;
            S_FINAL:  o_cmd.do_final = 1'b1;
            S_OUT:    o_cmd.load_out = i_stat.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/edfs_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_dpath
// Ready table, slot scan, running task, time counter and result register.
// ----------------------------------------------------------------------------
module edfs_dpath
    import edfs_pkg::*;
#(
    parameter int READY_SLOTS = EDFS_READY_SLOTS,
    parameter int TIME_BITS   = EDFS_TIME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_op,
    input  logic [ID_W-1:0]    i_task_id,
    input  logic [FIELD_W-1:0] i_task_length,
    input  logic [FIELD_W-1:0] i_task_deadline,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_arrival_accepted,
    output logic               o_running_valid,
    output logic [ID_W-1:0]    o_running_task,
    output logic               o_task_started,
    output logic               o_retired_valid,
    output logic [ID_W-1:0]    o_retired_task,
    output logic               o_deadline_missed,
    output logic [FIELD_W-1:0] o_current_tick
);

    localparam int IDX_W = $clog2(READY_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(READY_SLOTS - 1);

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] rem;
        logic [TIME_BITS-1:0] dl;
    } t_entry;

    t_entry                 r_mem [READY_SLOTS];
    t_entry                 r_rdata;
    logic [READY_SLOTS-1:0] r_used;

    logic                 r_op;
    logic [ID_W-1:0]      r_in_id;
    logic [TIME_BITS-1:0] r_in_len;
    logic [TIME_BITS-1:0] r_in_dl;
    logic [TIME_BITS-1:0] r_tick_snap;

    logic                 r_scan_act;
    logic                 r_scan_free;
    logic [IDX_W-1:0]     r_scan_idx;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best;
    logic [TIME_BITS-1:0] r_best_dl;

    logic                 r_run_valid;
    logic [ID_W-1:0]      r_run_id;
    logic [TIME_BITS-1:0] r_run_rem;
    logic [TIME_BITS-1:0] r_run_dl;
    logic [TIME_BITS-1:0] r_now;

    logic            r_accepted;
    logic            r_started;
    logic            r_retired;
    logic [ID_W-1:0] r_ret_id;
    logic            r_missed;
    logic            r_swapped;

    logic               r_out_valid;
    logic               r_out_acc;
    logic               r_out_run_valid;
    logic [ID_W-1:0]    r_out_run_id;
    logic               r_out_started;
    logic               r_out_retired;
    logic [ID_W-1:0]    r_out_ret_id;
    logic               r_out_missed;
    logic [FIELD_W-1:0] r_out_tick;

    logic [31:0]      w_len_ext;
    logic [31:0]      w_dl_ext;
    logic [31:0]      w_tick_ext;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_we;
    t_entry           w_wdata;
    logic             w_hit;
    logic             w_out_free;

    assign w_len_ext  = 32'(i_task_length);
    assign w_dl_ext   = 32'(i_task_deadline);
    assign w_tick_ext = 32'(r_tick_snap);

    assign w_rd_addr  = r_scan_act ? r_scan_idx : r_best;
    assign w_we       = i_cmd.do_arrive | i_cmd.do_swap;
    assign w_wdata    = i_cmd.do_arrive ? t_entry'{r_in_id, r_in_len, r_in_dl}
                                        : t_entry'{r_run_id, r_run_rem, r_run_dl};

    assign w_hit = r_scan_free
        ? (!r_found && !r_used[r_cmp_idx])
        : (r_used[r_cmp_idx] && (!r_found || (r_rdata.dl < r_best_dl)));

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_best] <= w_wdata;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op        <= i_op;
            r_in_id     <= i_task_id;
            r_in_len    <= w_len_ext[TIME_BITS-1:0];
            r_in_dl     <= w_dl_ext[TIME_BITS-1:0];
            r_tick_snap <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_act  <= 1'b0;
            r_scan_free <= 1'b0;
            r_scan_idx  <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_idx   <= '0;
            r_found     <= 1'b0;
        end else begin
            r_cmp_vld <= r_scan_act;
            r_cmp_idx <= r_scan_idx;
            if (i_cmd.scan_start) begin
                r_scan_act  <= 1'b1;
                r_scan_free <= i_cmd.scan_free;
                r_scan_idx  <= '0;
                r_found     <= 1'b0;
            end else begin
                if (r_scan_act) begin
                    if (r_scan_idx == LAST_IDX) begin
                        r_scan_act <= 1'b0;
                    end else begin
                        r_scan_idx <= r_scan_idx + IDX_W'(1);
                    end
                end
                if (r_cmp_vld && w_hit) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && w_hit) begin
            r_best    <= r_cmp_idx;
            r_best_dl <= r_rdata.dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.do_arrive) begin
            r_used[r_best] <= 1'b1;
        end else if (i_cmd.do_start) begin
            r_used[r_best] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_rem   <= '0;
            r_run_dl    <= '0;
            r_now       <= '0;
        end else begin
            if (i_cmd.do_swap || i_cmd.do_start) begin
                r_run_valid <= 1'b1;
                r_run_id    <= r_rdata.id;
                r_run_rem   <= r_rdata.rem;
                r_run_dl    <= r_rdata.dl;
            end else if (i_cmd.do_retire) begin
                r_run_valid <= 1'b0;
                r_run_id    <= '0;
                r_run_rem   <= '0;
                r_run_dl    <= '0;
            end else if (i_cmd.do_final && r_run_valid && (r_run_rem != '0)) begin
                r_run_rem <= r_run_rem - TIME_BITS'(1);
            end
            if (i_cmd.do_final && (r_now != {TIME_BITS{1'b1}})) begin
                r_now <= r_now + TIME_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted <= 1'b0;
            r_started  <= 1'b0;
            r_retired  <= 1'b0;
            r_ret_id   <= '0;
            r_missed   <= 1'b0;
            r_swapped  <= 1'b0;
        end else if (i_cmd.latch_in) begin
            r_accepted <= 1'b0;
            r_started  <= 1'b0;
            r_retired  <= 1'b0;
            r_ret_id   <= '0;
            r_missed   <= 1'b0;
            r_swapped  <= 1'b0;
        end else begin
            if (i_cmd.do_arrive) begin
                r_accepted <= 1'b1;
            end
            if (i_cmd.do_swap) begin
                r_started <= 1'b1;
                r_swapped <= 1'b1;
            end
            if (i_cmd.do_start) begin
                r_started <= 1'b1;
            end
            if (i_cmd.do_retire) begin
                r_retired <= 1'b1;
                r_ret_id  <= r_run_id;
                r_missed  <= (r_run_rem != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_acc       <= r_accepted;
            r_out_run_valid <= r_run_valid;
            r_out_run_id    <= r_run_valid ? r_run_id : '0;
            r_out_started   <= r_started;
            r_out_retired   <= r_retired;
            r_out_ret_id    <= r_ret_id;
            r_out_missed    <= r_missed;
            r_out_tick      <= w_tick_ext[FIELD_W-1:0];
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.scan_busy = r_scan_act | r_cmp_vld;
    assign o_stat.found     = r_found;
    assign o_stat.preempt   = r_run_valid && r_found && (r_best_dl < r_run_dl);
    assign o_stat.retire    = r_run_valid && ((r_run_rem == '0) || (r_now == r_run_dl));
    assign o_stat.run_valid = r_run_valid;
    assign o_stat.swapped   = r_swapped;
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid        = r_out_valid;
    assign o_arrival_accepted = r_out_acc;
    assign o_running_valid    = r_out_run_valid;
    assign o_running_task     = r_out_run_id;
    assign o_task_started     = r_out_started;
    assign o_retired_valid    = r_out_retired;
    assign o_retired_task     = r_out_ret_id;
    assign o_deadline_missed  = r_out_missed;
    assign o_current_tick     = r_out_tick;

endmodule
`default_nettype wire
